// File: rtl/rrts_pkg.sv
// Round-robin thread scheduler: shared package.
// Event and result codes, default sizes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package rrts_pkg;

	localparam int unsigned SLOTS_DEFAULT = 16;
	localparam int unsigned QUANTUM_W     = 8;
	localparam int unsigned BUDGET_IN_W   = 23;
	localparam int unsigned BUDGET_W      = 24;
	localparam int unsigned OP_W          = 2;
	localparam int unsigned STATUS_W      = 3;
	localparam int unsigned SLOT_FIELD_W  = 4;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd20;

	typedef enum logic [OP_W-1:0] {
		OP_CREATE = 2'd0,
		OP_TICK   = 2'd1,
		OP_EXIT   = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_TICK    = 3'd0,
		ST_CREATED = 3'd1,
		ST_FULL    = 3'd2,
		ST_PREEMPT = 3'd3,
		ST_EJECT   = 3'd4,
		ST_EXIT    = 3'd5,
		ST_HALT    = 3'd6
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // input transaction taken, latch the event
		logic exec;   // apply the event and load the result register
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // result register can take a new result this cycle
	} ctl_stat_t;

endpackage

// File: rtl/rrts_if.sv
// Round-robin thread scheduler: channel interfaces.
// Event input, result output and quantum configuration channels.
// No dependencies.
`timescale 1ns / 1ps

interface sched_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [22:0] budget_ticks;

	modport source (output valid, output op, output budget_ticks, input ready);
	modport sink   (input valid, input op, input budget_ticks, output ready);
endinterface

interface sched_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] slot;
	logic [3:0] prev_slot;

	modport source (output valid, output status, output slot, output prev_slot, input ready);
	modport sink   (input valid, input status, input slot, input prev_slot, output ready);
endinterface

interface sched_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] quantum_length;

	modport source (output valid, output quantum_length, input ready);
	modport sink   (input valid, input quantum_length, output ready);
endinterface

// File: rtl/rrts_ctrl.sv
// Round-robin thread scheduler: controller.
// Sequences accept and execute of one event. Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rrts_pkg::ctl_stat_t stat,
	output rrts_pkg::ctl_cmd_t  cmd
);
	import rrts_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	assign in_ready = in_ready_q;
	assign cmd.load = in_valid && in_ready_q;
	assign cmd.exec = (state_q == S_EXEC) && stat.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= S_EXEC;
						in_ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					// wait here while the previous result is still unclaimed
					if (stat.out_free) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

// File: rtl/rrts_datapath.sv
// Round-robin thread scheduler: datapath.
// Slot tables, ready queue, running slot and result register. Depends on rrts_pkg.
`timescale 1ns / 1ps

module rrts_datapath #(
	parameter int unsigned THREAD_SLOTS = rrts_pkg::SLOTS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rrts_pkg::ctl_cmd_t         cmd,
	output rrts_pkg::ctl_stat_t        stat,
	input  logic [rrts_pkg::OP_W-1:0]        op,
	input  logic [rrts_pkg::BUDGET_IN_W-1:0] budget_ticks,
	input  logic [rrts_pkg::QUANTUM_W-1:0]   quantum_length,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [rrts_pkg::STATUS_W-1:0]     status,
	output logic [rrts_pkg::SLOT_FIELD_W-1:0] slot,
	output logic [rrts_pkg::SLOT_FIELD_W-1:0] prev_slot
);
	import rrts_pkg::*;

	localparam int unsigned SLOT_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
	localparam int unsigned CNT_W  = $clog2(THREAD_SLOTS + 1);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(THREAD_SLOTS - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(THREAD_SLOTS);

	// event latched at accept
	logic [OP_W-1:0]        op_q;
	logic [BUDGET_IN_W-1:0] budget_in_q;

	// slot tables and ready queue storage
	logic [QUANTUM_W-1:0] qt_mem   [THREAD_SLOTS];
	logic [BUDGET_W-1:0]  bud_mem  [THREAD_SLOTS];
	logic [SLOT_W-1:0]    fifo_mem [THREAD_SLOTS];
	logic [QUANTUM_W-1:0] qt_rd_q;
	logic [BUDGET_W-1:0]  bud_rd_q;
	logic [SLOT_W-1:0]    fifo_rd_q;

	// control state
	logic [THREAD_SLOTS-1:0] used_q, used_nxt;
	logic [SLOT_W-1:0]       head_q, head_nxt, tail_q, tail_nxt, run_q, run_nxt;
	logic [CNT_W-1:0]        count_q, count_nxt;
	logic                    halted_q, halted_nxt;
	logic                    boot_q, boot_nxt;   // slot 0 still the thread left by reset

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [SLOT_FIELD_W-1:0] slot_q, prev_slot_q;

	// event evaluation
	logic                 free_found;
	logic [SLOT_W-1:0]    free_idx;
	logic                 budget_out, quantum_out, fifo_empty, fifo_full;
	logic                 push, pop;
	logic [SLOT_W-1:0]    push_slot;
	logic                 qt_we, bud_we;
	logic [SLOT_W-1:0]    wr_slot;
	logic [QUANTUM_W-1:0] qt_wdata;
	logic [BUDGET_W-1:0]  bud_wdata;
	status_t              res_status;
	logic [SLOT_W-1:0]    res_slot;
	logic [SLOT_W+SLOT_FIELD_W-1:0] res_slot_ext, prev_slot_ext;

	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot          = slot_q;
	assign prev_slot     = prev_slot_q;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign budget_out = boot_q || (bud_rd_q == '0);
	assign quantum_out = (qt_rd_q <= QUANTUM_W'(1));
	assign fifo_empty  = (count_q == '0);
	assign fifo_full   = (count_q == FULL_CNT);

	always_comb begin
		used_nxt   = used_q;
		run_nxt    = run_q;
		halted_nxt = halted_q;
		boot_nxt   = boot_q;
		push       = 1'b0;
		pop        = 1'b0;
		push_slot  = run_q;
		qt_we      = 1'b0;
		bud_we     = 1'b0;
		wr_slot    = run_q;
		qt_wdata   = qt_rd_q - QUANTUM_W'(1);
		bud_wdata  = bud_rd_q - BUDGET_W'(1);
		res_status = ST_TICK;
		res_slot   = run_q;

		if (halted_q) begin
			res_status = ST_HALT;
		end else begin
			case (op_q)
				OP_CREATE: begin
					if (!free_found) begin
						res_status = ST_FULL;
						res_slot   = '0;
					end else begin
						used_nxt[free_idx] = 1'b1;
						qt_we      = 1'b1;
						bud_we     = 1'b1;
						wr_slot    = free_idx;
						qt_wdata   = quantum_length;
						bud_wdata  = {1'b0, budget_in_q};
						push       = !fifo_full;
						push_slot  = free_idx;
						res_status = ST_CREATED;
						res_slot   = free_idx;
					end
				end
				OP_TICK: begin
					qt_we  = 1'b1;
					bud_we = !budget_out;
					if (budget_out) begin
						used_nxt[run_q] = 1'b0;
						boot_nxt        = 1'b0;
						if (fifo_empty) begin
							halted_nxt = 1'b1;
							res_status = ST_HALT;
						end else begin
							pop        = 1'b1;
							run_nxt    = fifo_rd_q;
							res_status = ST_EJECT;
							res_slot   = fifo_rd_q;
						end
					end else if (quantum_out) begin
						qt_wdata = quantum_length;
						push     = !fifo_full;
						// an otherwise empty queue hands the same thread straight back
						pop      = !fifo_empty || !fifo_full;
						run_nxt  = fifo_empty ? run_q : fifo_rd_q;
						res_status = ST_PREEMPT;
						res_slot   = fifo_empty ? run_q : fifo_rd_q;
					end
				end
				OP_EXIT: begin
					used_nxt[run_q] = 1'b0;
					boot_nxt        = 1'b0;
					if (fifo_empty) begin
						halted_nxt = 1'b1;
						res_status = ST_HALT;
					end else begin
						pop        = 1'b1;
						run_nxt    = fifo_rd_q;
						res_status = ST_EXIT;
						res_slot   = fifo_rd_q;
					end
				end
				default: begin
					res_status = ST_TICK;
				end
			endcase
		end

		tail_nxt  = push ? ((tail_q == LAST_SLOT) ? '0 : tail_q + SLOT_W'(1)) : tail_q;
		head_nxt  = pop ? ((head_q == LAST_SLOT) ? '0 : head_q + SLOT_W'(1)) : head_q;
		count_nxt = count_q + CNT_W'(push) - CNT_W'(pop);
	end

	assign res_slot_ext  = {{SLOT_FIELD_W{1'b0}}, res_slot};
	assign prev_slot_ext = {{SLOT_FIELD_W{1'b0}}, run_q};

	// event latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q        <= op;
			budget_in_q <= budget_ticks;
		end
	end

	// tables: read data registered every cycle at the running slot and queue head
	always_ff @(posedge clk) begin
		qt_rd_q   <= qt_mem[run_q];
		bud_rd_q  <= bud_mem[run_q];
		fifo_rd_q <= fifo_mem[head_q];
		if (cmd.exec && qt_we) begin
			qt_mem[wr_slot] <= qt_wdata;
		end
		if (cmd.exec && bud_we) begin
			bud_mem[wr_slot] <= bud_wdata;
		end
		if (cmd.exec && push) begin
			fifo_mem[tail_q] <= push_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= {{(THREAD_SLOTS-1){1'b0}}, 1'b1};
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			run_q    <= '0;
			halted_q <= 1'b0;
			boot_q   <= 1'b1;
		end else if (cmd.exec) begin
			used_q   <= used_nxt;
			head_q   <= head_nxt;
			tail_q   <= tail_nxt;
			count_q  <= count_nxt;
			run_q    <= run_nxt;
			halted_q <= halted_nxt;
			boot_q   <= boot_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q    <= res_status;
			slot_q      <= res_slot_ext[SLOT_FIELD_W-1:0];
			prev_slot_q <= prev_slot_ext[SLOT_FIELD_W-1:0];
		end
	end

endmodule

// File: rtl/round_robin_thread_scheduler_top.sv
// Round-robin thread scheduler: top level.
// Joins controller and datapath, holds the quantum register. Depends on rrts_pkg,
// rrts_if, rrts_ctrl and rrts_datapath.
`timescale 1ns / 1ps

// Each input transaction is one scheduler event (create, timer tick or exit) and
// produces exactly one result transaction. The slot quantum/budget tables and
// the ready queue are memories with registered read ports, addressed by the
// running slot and the queue head, so the event is latched at accept and applied
// in the execute state once the result register is free. Input ready
// returns the cycle after the event is applied; a result left unclaimed on the
// output holds off only the next event's apply step, so the next event can still
// be accepted. There is no clearing pass after reset: table entries are always
// written by a create before they are read, and the thread in slot 0 left by
// reset is tracked by a flag and treated as having no budget. The user must write
// the quantum register through the configuration channel only while no event is
// in flight; the block itself does not enforce it. It resets to 20 ticks.

module round_robin_thread_scheduler_top #(
	parameter int unsigned THREAD_SLOTS = rrts_pkg::SLOTS_DEFAULT
) (
	input logic         clk,
	input logic         arst_n,
	sched_in_if.sink    in_ch,
	sched_out_if.source out_ch,
	sched_cfg_if.sink   cfg
);
	import rrts_pkg::*;

	logic [QUANTUM_W-1:0] quantum_length_q;
	ctl_cmd_t             cmd;
	ctl_stat_t            stat;

	// configuration is always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_length_q <= QUANTUM_RESET;
		end else if (cfg.valid) begin
			quantum_length_q <= cfg.quantum_length;
		end
	end

	rrts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rrts_datapath #(
		.THREAD_SLOTS (THREAD_SLOTS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.op             (in_ch.op),
		.budget_ticks   (in_ch.budget_ticks),
		.quantum_length (quantum_length_q),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.status         (out_ch.status),
		.slot           (out_ch.slot),
		.prev_slot      (out_ch.prev_slot)
	);

endmodule

// File: sim/testbench.sv
// Testbench for the round-robin thread scheduler: directed corners, random event
// streams over several quantum settings, a long result hold and the final halt.
// Depends on rrts_pkg, rrts_if and round_robin_thread_scheduler_top.
`timescale 1ns / 1ps

module testbench;
	import rrts_pkg::*;

	localparam int unsigned SLOTS = SLOTS_DEFAULT;

	// op 3 is not a defined event; the block must answer it without changing state
	localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

	localparam int CYCLE_LIMIT  = 500_000; // far beyond the slowest legal run
	localparam int SETTLE_CYCLES = 4;      // event path drain plus margin
	localparam int TAIL_CYCLES   = 20;
	localparam int HOLD_CYCLES   = 400;    // long result hold, fills the block

	typedef struct packed {
		status_t                 status;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [SLOT_FIELD_W-1:0] prev_slot;
	} sched_result_t;

	logic clk;
	logic arst_n;

	sched_in_if  in_ch ();
	sched_out_if out_ch ();
	sched_cfg_if cfg_ch ();

	round_robin_thread_scheduler_top #(
		.THREAD_SLOTS(SLOTS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	// ------------------------------------------------------------------
	// Scheduler shadow state: slot table, ready queue, running slot
	// ------------------------------------------------------------------
	bit                      slot_busy    [SLOTS];
	logic [QUANTUM_W-1:0]    quantum_left [SLOTS];
	logic [BUDGET_W-1:0]     budget_left  [SLOTS];
	logic [SLOT_FIELD_W-1:0] ready_q      [$];
	logic [SLOT_FIELD_W-1:0] running_slot;
	bit                      sched_halted;
	logic [QUANTUM_W-1:0]    quantum_len;

	// results still owed by the block, oldest first
	sched_result_t expected_results [$];

	int  errors;
	int  events_sent;
	int  results_seen;
	int  status_seen [0:7];
	int  cycle_count;
	int  result_hold_cycles; // set by a test, consumed by the result process
	bit  tx_gaps;
	bit  rx_gaps;

	// Applies one event to the shadow state and returns the result it must give.
	function automatic sched_result_t schedule_event(input logic [OP_W-1:0] op,
			input logic [BUDGET_IN_W-1:0] budget);
		logic [SLOT_FIELD_W-1:0] prev;
		int                      free_idx;
		bit                      budget_out;
		bit                      quantum_out;
		prev     = running_slot;
		free_idx = -1;
		if (sched_halted)
			return '{ST_HALT, prev, prev};
		case (op)
			OP_CREATE: begin
				// lowest free slot wins
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!slot_busy[i])
						free_idx = i;
				if (free_idx < 0)
					return '{ST_FULL, 4'd0, prev};
				slot_busy[free_idx]    = 1'b1;
				quantum_left[free_idx] = quantum_len;
				budget_left[free_idx]  = {1'b0, budget};
				if (ready_q.size() < SLOTS)
					ready_q.push_back(free_idx[SLOT_FIELD_W-1:0]);
				return '{ST_CREATED, free_idx[SLOT_FIELD_W-1:0], prev};
			end
			OP_TICK: begin
				budget_out  = (budget_left[prev] == 0);
				quantum_out = (quantum_left[prev] <= 1);
				quantum_left[prev] = quantum_left[prev] - 8'd1;
				if (!budget_out)
					budget_left[prev] = budget_left[prev] - 24'd1;
				if (budget_out) begin
					slot_busy[prev] = 1'b0;
					if (ready_q.size() == 0) begin
						sched_halted = 1'b1;
						return '{ST_HALT, prev, prev};
					end
					running_slot = ready_q.pop_front();
					return '{ST_EJECT, running_slot, prev};
				end
				if (quantum_out) begin
					// requeue behind the others; alone it simply runs again
					quantum_left[prev] = quantum_len;
					if (ready_q.size() < SLOTS)
						ready_q.push_back(prev);
					running_slot = ready_q.pop_front();
					return '{ST_PREEMPT, running_slot, prev};
				end
				return '{ST_TICK, prev, prev};
			end
			OP_EXIT: begin
				slot_busy[prev] = 1'b0;
				if (ready_q.size() == 0) begin
					sched_halted = 1'b1;
					return '{ST_HALT, prev, prev};
				end
				running_slot = ready_q.pop_front();
				return '{ST_EXIT, running_slot, prev};
			end
			default: return '{ST_TICK, prev, prev};
		endcase
	endfunction

	// Random event choice. Exits and fatal ticks are held back while the ready
	// queue is empty, so the scheduler never halts before the final test.
	function automatic logic [OP_W-1:0] pick_event();
		int r;
		bit can_tick;
		bit can_exit;
		r        = $urandom_range(0, 99);
		can_exit = (ready_q.size() != 0);
		can_tick = can_exit || (budget_left[running_slot] != 0);
		if (r < 2)
			return OP_UNDEFINED;
		if (r < 27)
			return OP_CREATE;
		if (r < 37 && can_exit)
			return OP_EXIT;
		if (can_tick)
			return OP_TICK;
		return OP_CREATE;
	endfunction

	// Mostly short budgets so that ejections are common, with a few huge ones.
	function automatic logic [BUDGET_IN_W-1:0] pick_budget();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return BUDGET_IN_W'($urandom_range(0, 30));
		if (r < 88)
			return BUDGET_IN_W'($urandom_range(0, 400));
		if (r < 94)
			return {BUDGET_IN_W{1'b1}};
		return BUDGET_IN_W'($urandom_range(0, (1 << BUDGET_IN_W) - 1));
	endfunction

	// ------------------------------------------------------------------
	// Event sender: one transaction per call. valid is only lowered when a
	// gap is drawn, so back-to-back events keep it high across the edge.
	// ------------------------------------------------------------------
	task automatic send_event(input logic [OP_W-1:0] op, input logic [BUDGET_IN_W-1:0] budget);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 19) : 0;
		if ($urandom_range(0, 63) == 0)
			tx_gaps = !tx_gaps;
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.op           <= op;
		in_ch.budget_ticks <= budget;
		do @(posedge clk); while (!in_ch.ready);
		expected_results.push_back(schedule_event(op, budget));
		events_sent++;
	endtask

	// Stops offering events, waits for every owed result, then lets the
	// event path empty out before anything else is touched.
	task automatic settle_pipeline();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_quantum(input logic [QUANTUM_W-1:0] quantum);
		@(negedge clk);
		cfg_ch.valid          <= 1'b1;
		cfg_ch.quantum_length <= quantum;
		do @(posedge clk); while (!cfg_ch.ready);
		quantum_len = quantum;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset thread, budget extremes, undefined op, table full, eject and exit
	// handover. Runs on the reset quantum.
	task automatic test_event_corners();
		send_event(OP_CREATE, {BUDGET_IN_W{1'b1}}); // slot 1, largest budget
		send_event(OP_CREATE, '0);                  // slot 2, no budget at all
		send_event(OP_TICK, '0);                    // reset thread has no budget: ejected
		send_event(OP_UNDEFINED, {BUDGET_IN_W{1'b1}});
		send_event(OP_EXIT, '0);                    // slot 1 leaves, slot 2 runs
		// refill every free slot (0, 1, 3..15), then one create too many
		for (int i = 0; i < SLOTS - 1; i++)
			send_event(OP_CREATE, (i == 7) ? 23'h555555 : 23'($urandom_range(0, 40)));
		send_event(OP_CREATE, 23'h2AAAAA);          // table full
		send_event(OP_TICK, '0);                    // slot 2 ejected, queue head runs
	endtask

	// Random event stream under one quantum. With hold_at >= 0 the result side
	// is held off for a long stretch from that event on while sending goes on.
	task automatic test_random_schedule(input logic [QUANTUM_W-1:0] quantum,
			input int n_events, input int hold_at);
		logic [OP_W-1:0] op;
		settle_pipeline();
		set_quantum(quantum);
		for (int k = 0; k < n_events; k++) begin
			if (k == hold_at)
				result_hold_cycles = HOLD_CYCLES;
			op = pick_event();
			send_event(op, (op == OP_CREATE) ? pick_budget()
			                                 : 23'($urandom_range(0, (1 << BUDGET_IN_W) - 1)));
		end
	endtask

	// Last test, since halting is permanent: a lone thread preempts itself,
	// then runs out of budget or exits with nothing queued, and the halted
	// block answers every further event the same way.
	task automatic test_self_preempt_and_halt();
		settle_pipeline();
		set_quantum(8'd1);
		while (ready_q.size() != 0)
			send_event(OP_EXIT, '0);
		send_event(OP_CREATE, 23'd2);
		send_event(OP_EXIT, '0);        // new thread now alone: quantum 1, budget 2
		repeat (2) send_event(OP_TICK, '0);
		if ($urandom_range(0, 1))
			send_event(OP_TICK, '0);    // budget gone, nothing to run
		else
			send_event(OP_EXIT, '0);    // exit with nothing to run
		send_event(OP_CREATE, {BUDGET_IN_W{1'b1}});
		send_event(OP_TICK, '0);
		send_event(OP_EXIT, '0);
		send_event(OP_UNDEFINED, '0);
	endtask

	// ------------------------------------------------------------------
	// Clock, watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("no completion within %0d cycles, %0d results still owed",
			CYCLE_LIMIT, expected_results.size());
		$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: random stalls, one long hold on request, and the check of
	// every result transaction against the oldest expectation.
	// ------------------------------------------------------------------
	initial begin : result_checker
		int            stall;
		sched_result_t want;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_gaps ? $urandom_range(0, 19) : 0;
			if ($urandom_range(0, 63) == 0)
				rx_gaps = !rx_gaps;
			if (result_hold_cycles > 0) begin
				stall              = result_hold_cycles;
				result_hold_cycles = 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			results_seen++;
			status_seen[out_ch.status]++;
			if (expected_results.size() == 0) begin
				$error("result with nothing owed: status %0d slot %0d prev_slot %0d",
					out_ch.status, out_ch.slot, out_ch.prev_slot);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (out_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_ch.status);
					errors++;
				end
				if (out_ch.slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, out_ch.slot);
					errors++;
				end
				if (out_ch.prev_slot !== want.prev_slot) begin
					$error("prev_slot: expected %0d, got %0d", want.prev_slot, out_ch.prev_slot);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_sequence
		// all inputs known from time zero, reset asserted from the start
		arst_n                = 1'b0;
		in_ch.valid           = 1'b0;
		in_ch.op              = OP_CREATE;
		in_ch.budget_ticks    = '0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.quantum_length = QUANTUM_RESET;
		tx_gaps               = 1'b1;
		rx_gaps               = 1'b1;
		errors                = 0;
		events_sent           = 0;
		results_seen          = 0;
		cycle_count           = 0;
		result_hold_cycles    = 0;
		foreach (status_seen[s])
			status_seen[s] = 0;

		// shadow state after reset: slot 0 running with a full quantum, no budget
		for (int i = 0; i < SLOTS; i++) begin
			slot_busy[i]    = 1'b0;
			quantum_left[i] = '0;
			budget_left[i]  = '0;
		end
		quantum_len     = QUANTUM_RESET;
		slot_busy[0]    = 1'b1;
		quantum_left[0] = QUANTUM_RESET;
		running_slot    = '0;
		sched_halted    = 1'b0;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		test_event_corners();
		test_random_schedule(8'd255, 350, -1);
		test_random_schedule(8'd1, 300, -1);
		test_random_schedule(8'($urandom_range(2, 254)), 350, 60);
		test_random_schedule(8'($urandom_range(2, 30)), 350, -1);
		test_random_schedule(QUANTUM_RESET, 300, -1);
		test_self_preempt_and_halt();

		settle_pipeline();
		repeat (TAIL_CYCLES) @(posedge clk); // catch any stray result transaction

		$display("Ran %0d events, %0d results checked, quantum 1 to 255, one long result hold.",
			events_sent, results_seen);
		$display("By status: tick %0d created %0d full %0d preempt %0d eject %0d exit %0d halt %0d",
			status_seen[ST_TICK], status_seen[ST_CREATED], status_seen[ST_FULL],
			status_seen[ST_PREEMPT], status_seen[ST_EJECT], status_seen[ST_EXIT],
			status_seen[ST_HALT]);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: round_robin_thread_scheduler_top.f
rtl/rrts_pkg.sv
rtl/rrts_if.sv
rtl/rrts_ctrl.sv
rtl/rrts_datapath.sv
rtl/round_robin_thread_scheduler_top.sv
sim/testbench.sv
